// ----- src/best_fit_pool_allocator_assert.svh -----
// Assertion macros for the best-fit pool allocator checker.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef BEST_FIT_POOL_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_POOL_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bfpa_pkg.sv -----
`timescale 1ns / 1ps
// Shared sizes, derived widths and codes of the best-fit pool allocator.
// Used by the top level and by its port checker; depends on nothing.
package bfpa_pkg;

	localparam int NUM_POOLS   = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int MAX_RESULTS = 16;

	// Fixed field widths of the request and result ports.
	localparam int IDX_FIELD_W = 4;
	localparam int CAP_FIELD_W = 16;
	localparam int REQ_FIELD_W = 20;
	localparam int ST_FIELD_W  = 2;

	localparam int IDX_W   = $clog2(NUM_POOLS);
	localparam int CNT_W   = $clog2(NUM_POOLS + 1);
	localparam int SUM_W   = COUNT_WIDTH + $clog2(NUM_POOLS);
	localparam int TOTAL_W = (SUM_W > REQ_FIELD_W) ? SUM_W : REQ_FIELD_W;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	localparam logic [ST_FIELD_W-1:0] ST_GRANT  = 2'd0;
	localparam logic [ST_FIELD_W-1:0] ST_REJECT = 2'd1;
	localparam logic [ST_FIELD_W-1:0] ST_EMPTY  = 2'd2;

endpackage

// ----- src/best_fit_pool_allocator.sv -----
`timescale 1ns / 1ps
// Best-fit pool allocator: pool counters, running total and the selection sequencer.
// Depends on bfpa_pkg for sizes, widths and status codes.

// A request is taken when start is high and busy is low. A load (mode 0) sets
// one pool's free capacity; after the accept, the load state reads the old
// value and adjusts the total, and the load gives no result. A request
// (mode 1) that asks for more than the total free units gives one rejected
// result, and a request for zero gives one empty result; both appear on the
// cycle after the accept and the block stays ready. Any other request runs
// selection steps. Each step walks all NUM_POOLS counters through one shared
// compare unit, one pool per cycle, and then debits the chosen pool in the
// apply state. Busy stays high through the steps and a final walk of the
// pools in ascending order that reports the grants; a request takes one step
// when one pool can cover the whole amount and at most NUM_POOLS steps.
// Results are shown for exactly one cycle with valid high; the receiver cannot
// hold them off, so it must take every result as it comes. The last result of
// a request carries last high.
module best_fit_pool_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic [bfpa_pkg::IDX_FIELD_W-1:0]   pool_index,
	input  logic [bfpa_pkg::CAP_FIELD_W-1:0]   capacity,
	input  logic [bfpa_pkg::REQ_FIELD_W-1:0]   request_amount,
	output logic                               valid,
	output logic [bfpa_pkg::ST_FIELD_W-1:0]    status,
	output logic [bfpa_pkg::IDX_FIELD_W-1:0]   granted_pool,
	output logic [bfpa_pkg::CAP_FIELD_W-1:0]   granted_amount,
	output logic                               last
);

	localparam int NP   = bfpa_pkg::NUM_POOLS;
	localparam int CW   = bfpa_pkg::COUNT_WIDTH;
	localparam int IW   = bfpa_pkg::IDX_W;
	localparam int NW   = bfpa_pkg::CNT_W;
	localparam int TW   = bfpa_pkg::TOTAL_W;
	localparam int IFW  = bfpa_pkg::IDX_FIELD_W;
	localparam int CFW  = bfpa_pkg::CAP_FIELD_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LOAD  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_APPLY = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// Pool counters and the per-request grant record.
	logic [CW-1:0] pool_free_q  [NP];
	logic [CW-1:0] grant_amt_q  [NP];
	logic [NP-1:0] granted_q;
	logic [TW-1:0] total_q;

	// Sequencer registers.
	logic [IW-1:0] scan_q;
	logic [IW-1:0] load_idx_q;
	logic          load_ok_q;
	logic [CW-1:0] load_cap_q;
	logic [TW-1:0] rem_q;
	logic          fit_found_q;
	logic [IW-1:0] fit_idx_q;
	logic [CW-1:0] fit_val_q;
	logic [IW-1:0] big_idx_q;
	logic [CW-1:0] big_val_q;
	logic [NW-1:0] grant_cnt_q;
	logic [NW-1:0] emit_cnt_q;

	// Width adaptation of the input and output fields.
	logic [IW+IFW-1:0] idx_ext;
	logic [IW-1:0]     in_idx;
	logic              in_idx_ok;
	logic [CW+CFW-1:0] cap_ext;
	logic [CW-1:0]     in_cap;
	logic [IW+IFW-1:0] pool_out_ext;
	logic [CW+CFW-1:0] amt_out_ext;

	// Shared read port and compare unit.
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] rd_free;
	logic [TW-1:0] rd_free_ext;
	logic          fits;
	logic          tighter;
	logic          bigger;
	logic          scan_end;
	logic [NW-1:0] emit_target;
	logic          accept;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);

	assign idx_ext   = (IW + IFW)'(pool_index);
	assign in_idx    = idx_ext[IW-1:0];
	assign in_idx_ok = (32'(pool_index) < NP);
	assign cap_ext   = (CW + CFW)'(capacity);
	assign in_cap    = cap_ext[CW-1:0];

	assign rd_addr     = (state_q == S_LOAD) ? load_idx_q : scan_q;
	assign rd_free     = pool_free_q[rd_addr];
	assign rd_free_ext = TW'(rd_free);

	// A pool fits when it covers the remainder; among fitting pools the smaller
	// wins, and on equal values the later index wins since the walk ascends.
	assign fits     = (rd_free_ext >= rem_q);
	assign tighter  = !fit_found_q || (rd_free <= fit_val_q);
	assign bigger   = (rd_free >= big_val_q);
	assign scan_end = (scan_q == IW'(NP - 1));

	// Only the first MAX_RESULTS grants are reported.
	always_comb begin
		if (32'(grant_cnt_q) > bfpa_pkg::MAX_RESULTS) begin
			emit_target = NW'(bfpa_pkg::MAX_RESULTS);
		end else begin
			emit_target = grant_cnt_q;
		end
	end

	assign pool_out_ext = (IW + IFW)'(scan_q);
	assign amt_out_ext  = (CW + CFW)'(grant_amt_q[scan_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			granted_q   <= '0;
			scan_q      <= '0;
			fit_found_q <= 1'b0;
			grant_cnt_q <= '0;
			emit_cnt_q  <= '0;
			valid       <= 1'b0;
			for (int i = 0; i < NP; i++) begin
				pool_free_q[i] <= '0;
			end
		end else begin
			valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == bfpa_pkg::MODE_LOAD) begin
							load_idx_q <= in_idx;
							load_ok_q  <= in_idx_ok;
							load_cap_q <= in_cap;
							state_q    <= S_LOAD;
						end else if (TW'(request_amount) > total_q) begin
							valid          <= 1'b1;
							status         <= bfpa_pkg::ST_REJECT;
							granted_pool   <= '0;
							granted_amount <= '0;
							last           <= 1'b1;
						end else if (request_amount == '0) begin
							valid          <= 1'b1;
							status         <= bfpa_pkg::ST_EMPTY;
							granted_pool   <= '0;
							granted_amount <= '0;
							last           <= 1'b1;
						end else begin
							rem_q       <= TW'(request_amount);
							granted_q   <= '0;
							grant_cnt_q <= '0;
							scan_q      <= '0;
							fit_found_q <= 1'b0;
							big_val_q   <= '0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_LOAD: begin
					if (load_ok_q) begin
						pool_free_q[load_idx_q] <= load_cap_q;
						total_q <= total_q - rd_free_ext + TW'(load_cap_q);
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (fits && tighter) begin
						fit_found_q <= 1'b1;
						fit_idx_q   <= scan_q;
						fit_val_q   <= rd_free;
					end
					if (bigger) begin
						big_idx_q <= scan_q;
						big_val_q <= rd_free;
					end
					if (scan_end) begin
						state_q <= S_APPLY;
					end
					scan_q <= scan_q + 1'b1;
				end
				S_APPLY: begin
					scan_q      <= '0;
					fit_found_q <= 1'b0;
					big_val_q   <= '0;
					emit_cnt_q  <= '0;
					if (fit_found_q) begin
						// The best fit covers the rest and ends the request.
						pool_free_q[fit_idx_q] <= fit_val_q - rem_q[CW-1:0];
						grant_amt_q[fit_idx_q] <= rem_q[CW-1:0];
						granted_q[fit_idx_q]   <= 1'b1;
						total_q     <= total_q - rem_q;
						rem_q       <= '0;
						grant_cnt_q <= grant_cnt_q + 1'b1;
						state_q     <= S_EMIT;
					end else if (big_val_q == '0) begin
						// Nothing left to take from; report what was granted.
						if (grant_cnt_q == '0) begin
							valid          <= 1'b1;
							status         <= bfpa_pkg::ST_EMPTY;
							granted_pool   <= '0;
							granted_amount <= '0;
							last           <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						// Drain the largest pool and look again for the remainder.
						pool_free_q[big_idx_q] <= '0;
						grant_amt_q[big_idx_q] <= big_val_q;
						granted_q[big_idx_q]   <= 1'b1;
						total_q     <= total_q - TW'(big_val_q);
						rem_q       <= rem_q - TW'(big_val_q);
						grant_cnt_q <= grant_cnt_q + 1'b1;
						state_q     <= S_SCAN;
					end
				end
				S_EMIT: begin
					if (granted_q[scan_q] && (emit_cnt_q < emit_target)) begin
						valid          <= 1'b1;
						status         <= bfpa_pkg::ST_GRANT;
						granted_pool   <= pool_out_ext[IFW-1:0];
						granted_amount <= amt_out_ext[CFW-1:0];
						last           <= ((emit_cnt_q + 1'b1) == emit_target);
						emit_cnt_q     <= emit_cnt_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= S_IDLE;
					end
					scan_q <= scan_q + 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/bfpa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the best-fit pool allocator, bound to the top level.
// Depends on bfpa_pkg and the assertion macros in best_fit_pool_allocator_assert.svh.
`include "best_fit_pool_allocator_assert.svh"

module bfpa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             mode,
	input logic [bfpa_pkg::IDX_FIELD_W-1:0] pool_index,
	input logic [bfpa_pkg::CAP_FIELD_W-1:0] capacity,
	input logic [bfpa_pkg::REQ_FIELD_W-1:0] request_amount,
	input logic                             valid,
	input logic [bfpa_pkg::ST_FIELD_W-1:0]  status,
	input logic [bfpa_pkg::IDX_FIELD_W-1:0] granted_pool,
	input logic [bfpa_pkg::CAP_FIELD_W-1:0] granted_amount,
	input logic                             last
);

	logic load_taken;
	logic is_grant;
	logic single_res;
	logic grant_res;
	logic no_fields;
	logic has_units;
	logic more_due;

	assign load_taken = start && !busy && (mode == bfpa_pkg::MODE_LOAD);
	assign is_grant   = (status == bfpa_pkg::ST_GRANT);
	assign single_res = valid && !is_grant;
	assign grant_res  = valid && is_grant;
	assign no_fields  = (granted_pool == '0) && (granted_amount == '0);
	assign has_units  = (granted_amount != '0);
	assign more_due   = valid && !last;

	// Rejected and empty requests produce exactly one result.
	`BFPA_ASSERT_SAME(a_single_last, clk, arst_n, single_res, last, "single result without last")
	// Rejected and empty results carry no pool and no amount.
	`BFPA_ASSERT_SAME(a_single_zero, clk, arst_n, single_res, no_fields, "single result with fields")
	// A grant entry always moves some units.
	`BFPA_ASSERT_SAME(a_grant_amt, clk, arst_n, grant_res, has_units, "grant of zero units")
	// More grants are still to come, so the block must still be working.
	`BFPA_ASSERT_SAME(a_more_busy, clk, arst_n, more_due, busy, "idle before the last grant")
	// A load occupies the block for the cycle after its acceptance.
	`BFPA_ASSERT_NEXT(a_load_busy, clk, arst_n, load_taken, busy && !valid, "load not processed")

endmodule

bind best_fit_pool_allocator bfpa_checker u_bfpa_checker (.*);

// ----- tb/sv/best_fit_pool_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_pool_allocator: directed and random requests.
// It predicts every grant from its own pool bookkeeping. Depends on bfpa_pkg and the RTL.
module best_fit_pool_allocator_test;

	localparam int NP  = bfpa_pkg::NUM_POOLS;
	localparam int CW  = bfpa_pkg::COUNT_WIDTH;
	localparam int MR  = bfpa_pkg::MAX_RESULTS;
	localparam int TW  = bfpa_pkg::TOTAL_W;
	localparam int IFW = bfpa_pkg::IDX_FIELD_W;
	localparam int CFW = bfpa_pkg::CAP_FIELD_W;
	localparam int RFW = bfpa_pkg::REQ_FIELD_W;
	localparam int SFW = bfpa_pkg::ST_FIELD_W;

	// The limit covers about 430 requests, the longest sender gaps and the paced
	// part of a correct run.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Quiet cycles after the last expected result, longer than one full request.
	localparam int TAIL_CYCLES = 300;

	// One expected result of an allocation request.
	typedef struct packed {
		logic [SFW-1:0] status;
		logic [IFW-1:0] pool;
		logic [CFW-1:0] amount;
		logic           last;
	} grant_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic           mode;
	logic [IFW-1:0] pool_index;
	logic [CFW-1:0] capacity;
	logic [RFW-1:0] request_amount;
	logic           valid;
	logic [SFW-1:0] status;
	logic [IFW-1:0] granted_pool;
	logic [CFW-1:0] granted_amount;
	logic           last;

	// Our own copy of the allocator state: free units per pool and their sum.
	logic [CW-1:0] pool_units [NP];
	logic [TW-1:0] units_total;

	// Results predicted at accept time, oldest first.
	grant_t grants_due[$];
	grant_t due;

	int mismatch_count = 0;
	int cycle_count    = 0;
	// Number of upcoming requests that go out back to back with no idle cycle.
	int burst_left     = 0;

	best_fit_pool_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.pool_index     (pool_index),
		.capacity       (capacity),
		.request_amount (request_amount),
		.valid          (valid),
		.status         (status),
		.granted_pool   (granted_pool),
		.granted_amount (granted_amount),
		.last           (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Applies one accepted request to the predicted state and queues the results
	// it must produce. A load replaces one pool's count and moves the total by the
	// difference, so reloads are handled the same way as first loads.
	function automatic void predict_grants(input logic m, input logic [IFW-1:0] idx,
			input logic [CFW-1:0] cap, input logic [RFW-1:0] amount);
		logic [TW-1:0] remaining;
		logic [CW-1:0] taken [NP];
		logic [CW-1:0] drained;
		grant_t        g;
		int            fit;
		int            big;
		int            n_grants;
		int            n;

		if (m == bfpa_pkg::MODE_LOAD) begin
			if (int'(idx) < NP) begin
				units_total = units_total - pool_units[idx] + cap[CW-1:0];
				pool_units[idx] = cap[CW-1:0];
			end
			return;
		end

		g = '0;
		g.last = 1'b1;
		if (amount > units_total) begin
			g.status = bfpa_pkg::ST_REJECT;
			grants_due.push_back(g);
			return;
		end
		if (amount == '0) begin
			g.status = bfpa_pkg::ST_EMPTY;
			grants_due.push_back(g);
			return;
		end

		remaining = amount;
		for (int p = 0; p < NP; p++) taken[p] = '0;

		// Each step takes the tightest pool that covers what is left; failing that
		// it empties the biggest pool. Ties go to the higher pool index.
		for (int step = 0; step <= NP && remaining != '0; step++) begin
			fit = -1;
			big = -1;
			for (int p = 0; p < NP; p++) begin
				if (pool_units[p] >= remaining && (fit < 0 || pool_units[p] <= pool_units[fit]))
					fit = p;
				if (big < 0 || pool_units[p] >= pool_units[big])
					big = p;
			end
			if (fit >= 0) begin
				pool_units[fit] = pool_units[fit] - remaining[CW-1:0];
				taken[fit]      = taken[fit] + remaining[CW-1:0];
				units_total     = units_total - remaining;
				remaining       = '0;
			end else begin
				drained = pool_units[big];
				if (drained == '0) break;
				pool_units[big] = '0;
				taken[big]      = taken[big] + drained;
				units_total     = units_total - drained;
				remaining       = remaining - drained;
			end
		end

		// Grants are reported in ascending pool order, at most MAX_RESULTS of them.
		n_grants = 0;
		for (int p = 0; p < NP; p++)
			if (taken[p] != '0) n_grants++;
		if (n_grants > MR) n_grants = MR;

		n = 0;
		for (int p = 0; p < NP && n < n_grants; p++) begin
			if (taken[p] != '0) begin
				g.status = bfpa_pkg::ST_GRANT;
				g.pool   = IFW'(p);
				g.amount = taken[p];
				g.last   = (n + 1 == n_grants);
				grants_due.push_back(g);
				n++;
			end
		end
		if (n == 0) begin
			g = '0;
			g.status = bfpa_pkg::ST_EMPTY;
			g.last   = 1'b1;
			grants_due.push_back(g);
		end
	endfunction

	// Sender idle length: mostly none or short, now and then long, and from time to
	// time a burst of requests sent back to back.
	function automatic int pick_gap();
		int r;

		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = int'($urandom_range(0, 99));
		if (r < 3) begin
			burst_left = 20;
			return 0;
		end
		if (r < 50) return 0;
		if (r < 90) return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 60));
	endfunction

	// Presents one request at a falling edge and holds it until the block takes it.
	// With no gap the next call changes the fields at the next falling edge while
	// start stays high, so back-to-back requests really are back to back.
	task automatic send_item(input logic m, input logic [IFW-1:0] idx,
			input logic [CFW-1:0] cap, input logic [RFW-1:0] amount);
		int gap;

		@(negedge clk);
		start          = 1'b1;
		mode           = m;
		pool_index     = idx;
		capacity       = cap;
		request_amount = amount;
		do @(posedge clk); while (busy);
		predict_grants(m, idx, cap, amount);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drops start and holds off until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] expected,
			input logic [31:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatch_count++;
		end
	endfunction

	// Every strobed result is taken as it comes and matched against the oldest
	// prediction; the block cannot be held off, so nothing here ever stalls.
	always @(posedge clk) begin
		if (arst_n && valid === 1'b1) begin
			if (grants_due.size() == 0) begin
				$error("result with nothing expected: status %0d pool %0d amount %0d last %0d",
					status, granted_pool, granted_amount, last);
				mismatch_count++;
			end else begin
				due = grants_due.pop_front();
				check_field("status", 32'(due.status), 32'(status));
				check_field("granted_pool", 32'(due.pool), 32'(granted_pool));
				check_field("granted_amount", 32'(due.amount), 32'(granted_amount));
				check_field("last", 32'(due.last), 32'(last));
			end
		end
	end

	// Empty-pool cases, tie breaking in both selection rules, a reload that shrinks a
	// pool, a two-pool split, the largest rejected amount and a request that drains
	// all sixteen full pools for the most results one request can give.
	task automatic test_directed_extremes();
		send_item(bfpa_pkg::MODE_REQUEST, '0, '0, '0);
		send_item(bfpa_pkg::MODE_REQUEST, '0, '0, 20'd1);
		send_item(bfpa_pkg::MODE_LOAD, 4'd15, 16'hFFFF, '0);
		send_item(bfpa_pkg::MODE_LOAD, 4'd0, 16'hFFFF, '0);
		send_item(bfpa_pkg::MODE_REQUEST, '0, '0, 20'd1);
		send_item(bfpa_pkg::MODE_LOAD, 4'd15, 16'h0010, '0);
		send_item(bfpa_pkg::MODE_REQUEST, '0, '0, 20'h1000F);
		send_item(bfpa_pkg::MODE_REQUEST, '0, '0, 20'hFFFFF);
		for (int p = 0; p < NP; p++)
			send_item(bfpa_pkg::MODE_LOAD, IFW'(p), 16'hFFFF, '0);
		send_item(bfpa_pkg::MODE_REQUEST, '0, '0, RFW'(NP * 16'hFFFF));
	endtask

	// One random request. Loads favor corner counts and copies of other pools (to
	// force ties); allocations mostly stay within the free total so that they reach
	// the multi-step path, with rejects, zeros and exact fits mixed in. Fields that
	// the current mode ignores carry random noise.
	task automatic send_random_item(input bit paced);
		logic           m;
		logic [IFW-1:0] idx;
		logic [CFW-1:0] cap;
		logic [RFW-1:0] amount;
		int             pick;

		idx    = IFW'($urandom_range(0, 15));
		cap    = CFW'($urandom_range(0, 16'hFFFF));
		amount = RFW'($urandom_range(0, 20'hFFFFF));
		if (units_total == '0)
			m = ($urandom_range(0, 9) < 7) ? bfpa_pkg::MODE_LOAD : bfpa_pkg::MODE_REQUEST;
		else
			m = ($urandom_range(0, 9) < 4) ? bfpa_pkg::MODE_LOAD : bfpa_pkg::MODE_REQUEST;

		pick = int'($urandom_range(0, 19));
		if (m == bfpa_pkg::MODE_LOAD) begin
			unique case (pick % 10)
				0:       cap = '0;
				1:       cap = '1;
				2, 3:    cap = CFW'($urandom_range(1, 15));
				4:       cap = pool_units[$urandom_range(0, NP - 1)];
				5, 6:    cap = CFW'($urandom_range(16, 4095));
				default: ;
			endcase
		end else begin
			unique case (pick)
				0:          amount = '0;
				1:          amount = (units_total < 20'hFFFFF) ?
				                     RFW'($urandom_range(units_total + 1, 20'hFFFFF)) : '1;
				2:          ;
				3:          amount = units_total;
				4:          amount = RFW'(pool_units[$urandom_range(0, NP - 1)]);
				5, 6, 7, 8: amount = RFW'($urandom_range(1, 64));
				default:    amount = (units_total > 0) ?
				                     RFW'($urandom_range(1, units_total)) : '0;
			endcase
		end
		send_item(m, idx, cap, amount);
		if (paced) wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items);
		for (int k = 0; k < n_items; k++) send_random_item(1'b0);
	endtask

	// The sender waits for each request's results before it sends the next one.
	task automatic test_paced_traffic(input int n_items);
		for (int k = 0; k < n_items; k++) send_random_item(1'b1);
	endtask

	initial begin
		for (int p = 0; p < NP; p++) pool_units[p] = '0;
		units_total    = '0;
		arst_n         = 1'b0;
		start          = 1'b0;
		mode           = bfpa_pkg::MODE_LOAD;
		pool_index     = '0;
		capacity       = '0;
		request_amount = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed_extremes();
		test_random_traffic(360);
		test_paced_traffic(45);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- best_fit_pool_allocator.f -----
+incdir+src
src/bfpa_pkg.sv
src/best_fit_pool_allocator.sv
src/bfpa_checker.sv
tb/sv/best_fit_pool_allocator_test.sv
